// ----- sv/ogcm_pkg.sv -----
`timescale 1ns / 1ps
package ogcm_pkg;

   // Sizing of the frame counters and of the index fraction
   localparam int CELL_COUNT_BITS = 24;
   localparam int INDEX_FRAC_BITS = 16;

   localparam int CELL_W  = 8;
   localparam int COUNT_W = CELL_COUNT_BITS + 1;
   localparam int SUM_W   = COUNT_W + 1;
   localparam int REM_W   = SUM_W + 1;
   localparam int INDEX_W = INDEX_FRAC_BITS + 1;
   localparam int STEP_W  = $clog2(INDEX_FRAC_BITS);

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] CSR_UNKNOWN_IDX  = 2'd0;
   localparam logic [1:0] CSR_OCCUPIED_IDX = 2'd1;
   localparam logic [1:0] CSR_FREE_IDX     = 2'd2;

   localparam logic [CELL_W-1:0] UNKNOWN_RESET  = 8'd205;
   localparam logic [CELL_W-1:0] OCCUPIED_RESET = 8'd0;
   localparam logic [CELL_W-1:0] FREE_RESET     = 8'd254;

   // Index status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_KNOWN = 2'd1;
   localparam logic [1:0] STATUS_INVALID  = 2'd2;

   // Controller commands to the datapath
   typedef struct packed {
      logic take_pair;    // accept a pair that is not the frame's last
      logic take_last;    // accept the frame's last pair, start the divide
      logic div_step;     // one restoring divide step
      logic load_result;  // move the last pair's result to the output
   } ogcm_cmd_type;

   // Cell codes from the configuration registers
   typedef struct packed {
      logic [CELL_W-1:0] unknown_code;
      logic [CELL_W-1:0] occupied_code;
      logic [CELL_W-1:0] free_code;
   } ogcm_codes_type;

endpackage

// ----- sv/ogcm_csr.sv -----
`timescale 1ns / 1ps
module ogcm_csr import ogcm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output ogcm_codes_type        codes
);

   logic [CELL_W-1:0] unknown_ff, unknown_in;
   logic [CELL_W-1:0] occupied_ff, occupied_in;
   logic [CELL_W-1:0] free_ff, free_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Decode the write transfer
   always_comb begin
      unknown_in  = unknown_ff;
      occupied_in = occupied_ff;
      free_in     = free_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_UNKNOWN_IDX:  unknown_in  = csr_pwdata[CELL_W-1:0];
            CSR_OCCUPIED_IDX: occupied_in = csr_pwdata[CELL_W-1:0];
            CSR_FREE_IDX:     free_in     = csr_pwdata[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unknown_ff  <= UNKNOWN_RESET;
         occupied_ff <= OCCUPIED_RESET;
         free_ff     <= FREE_RESET;
      end else begin
         unknown_ff  <= unknown_in;
         occupied_ff <= occupied_in;
         free_ff     <= free_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         CSR_UNKNOWN_IDX:  csr_prdata = {{(CSR_DATA_W-CELL_W){1'b0}}, unknown_ff};
         CSR_OCCUPIED_IDX: csr_prdata = {{(CSR_DATA_W-CELL_W){1'b0}}, occupied_ff};
         CSR_FREE_IDX:     csr_prdata = {{(CSR_DATA_W-CELL_W){1'b0}}, free_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign codes.unknown_code  = unknown_ff;
   assign codes.occupied_code = occupied_ff;
   assign codes.free_code     = free_ff;

endmodule

// ----- sv/ogcm_ctrl.sv -----
`timescale 1ns / 1ps
module ogcm_ctrl import ogcm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_frame_last,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ogcm_cmd_type cmd
);

   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_DIV = 2'd1;
   localparam logic [1:0] ST_FIN = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              accept;

   // Output register can take a new result this cycle
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_RUN) & out_free;
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_RUN: begin
            step_in = '0;
            if (accept) begin
               if (req_frame_last) begin
                  cmd.take_last = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  cmd.take_pair = 1'b1;
                  rsp_valid_in  = 1'b1;
               end
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(INDEX_FRAC_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hold the result until the output register drains
            if (out_free) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- sv/ogcm_datapath.sv -----
`timescale 1ns / 1ps
module ogcm_datapath import ogcm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ogcm_cmd_type        cmd,
   input  ogcm_codes_type      codes,
   input  logic [CELL_W-1:0]   req_ref_cell,
   input  logic [CELL_W-1:0]   req_align_cell,
   output logic [CELL_W-1:0]   rsp_merged_cell,
   output logic                rsp_cell_invalid,
   output logic                rsp_frame_done,
   output logic [INDEX_W-1:0]  rsp_agree_ratio,
   output logic [1:0]          rsp_index_status
);

   logic [CELL_W-1:0]  r, a, unk, occ, fre;
   logic               r_known, a_known, r_unk, a_unk;
   logic [CELL_W-1:0]  merged;
   logic               bad, foreign, counted;
   logic [COUNT_W-1:0] agree_upd, disagree_upd;

   logic [COUNT_W-1:0]         agree_ff, agree_in;
   logic [COUNT_W-1:0]         disagree_ff, disagree_in;
   logic                       inv_seen_ff, inv_seen_in;
   logic [SUM_W-1:0]           rem_ff, den_ff;
   logic [INDEX_FRAC_BITS-1:0] quo_ff;
   logic                       full_ff, frame_bad_ff;
   logic [CELL_W-1:0]          hold_merged_ff;
   logic                       hold_invalid_ff;
   logic [REM_W-1:0]           shifted, diff;
   logic                       fits;

   logic [CELL_W-1:0]  out_merged_ff;
   logic               out_invalid_ff, out_done_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic [1:0]         out_status_ff;

   assign r   = req_ref_cell;
   assign a   = req_align_cell;
   assign unk = codes.unknown_code;
   assign occ = codes.occupied_code;
   assign fre = codes.free_code;

   assign r_known = (r == occ) | (r == fre);
   assign a_known = (a == occ) | (a == fre);
   assign r_unk   = (r == unk);
   assign a_unk   = (a == unk);

   // Merge rules, tested in priority order
   always_comb begin
      bad = 1'b0;
      priority if (r == a) begin
         merged = r;
      end else if (((r == occ) & (a == fre)) | ((r == fre) & (a == occ))) begin
         merged = occ;
      end else if (r_unk & a_known) begin
         merged = a;
      end else if (a_unk & r_known) begin
         merged = r;
      end else begin
         merged = unk;
         bad    = 1'b1;
      end
   end

   assign foreign = ~(r_unk | r_known) | ~(a_unk | a_known);
   assign counted = ~bad & ~r_unk & ~a_unk & r_known & a_known;

   // Saturating counts including the current pair
   always_comb begin
      agree_upd    = agree_ff;
      disagree_upd = disagree_ff;
      if (counted) begin
         if (r == a) begin
            if (~&agree_ff) agree_upd = agree_ff + 1'b1;
         end else begin
            if (~&disagree_ff) disagree_upd = disagree_ff + 1'b1;
         end
      end
   end

   always_comb begin
      agree_in    = agree_ff;
      disagree_in = disagree_ff;
      inv_seen_in = inv_seen_ff;
      if (cmd.take_pair) begin
         agree_in    = agree_upd;
         disagree_in = disagree_upd;
         inv_seen_in = inv_seen_ff | bad | foreign;
      end else if (cmd.take_last) begin
         // Clear for the next frame
         agree_in    = '0;
         disagree_in = '0;
         inv_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agree_ff    <= '0;
         disagree_ff <= '0;
         inv_seen_ff <= 1'b0;
      end else begin
         agree_ff    <= agree_in;
         disagree_ff <= disagree_in;
         inv_seen_ff <= inv_seen_in;
      end
   end

   // Restoring divide step
   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.take_last) begin
         rem_ff          <= SUM_W'(agree_upd);
         den_ff          <= SUM_W'(agree_upd) + SUM_W'(disagree_upd);
         quo_ff          <= '0;
         full_ff         <= (disagree_upd == '0);
         frame_bad_ff    <= inv_seen_ff | bad | foreign;
         hold_merged_ff  <= merged;
         hold_invalid_ff <= bad;
      end else if (cmd.div_step) begin
         rem_ff <= fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
         quo_ff <= {quo_ff[INDEX_FRAC_BITS-2:0], fits};
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.take_pair) begin
         out_merged_ff  <= merged;
         out_invalid_ff <= bad;
         out_done_ff    <= 1'b0;
         out_index_ff   <= '0;
         out_status_ff  <= STATUS_OK;
      end else if (cmd.load_result) begin
         out_merged_ff  <= hold_merged_ff;
         out_invalid_ff <= hold_invalid_ff;
         out_done_ff    <= 1'b1;
         priority if (frame_bad_ff) begin
            out_index_ff  <= '0;
            out_status_ff <= STATUS_INVALID;
         end else if (den_ff == '0) begin
            out_index_ff  <= '0;
            out_status_ff <= STATUS_NO_KNOWN;
         end else if (full_ff) begin
            out_index_ff  <= INDEX_W'(1) << INDEX_FRAC_BITS;
            out_status_ff <= STATUS_OK;
         end else begin
            out_index_ff  <= {1'b0, quo_ff};
            out_status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_merged_cell  = out_merged_ff;
   assign rsp_cell_invalid = out_invalid_ff;
   assign rsp_frame_done   = out_done_ff;
   assign rsp_agree_ratio  = out_index_ff;
   assign rsp_index_status = out_status_ff;

endmodule

// ----- sv/occupancy_grid_cell_merge_core.sv -----
`timescale 1ns / 1ps
// Ordinary pair: result registered in the cycle after its transfer; one pair per
// cycle unless the output stalls. Last pair of a frame: transfer, 16 restoring divide
// steps at one quotient bit per cycle, load; no pair is taken in that time.
// A new pair transfers only while the output register is empty or drains that cycle.
// Synchronous active-high reset clears counters, control and output valid,
// and restores the cell codes to their defaults (205, 0, 254).
module occupancy_grid_cell_merge_core import ogcm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CELL_W-1:0]     req_ref_cell,
   input  logic [CELL_W-1:0]     req_align_cell,
   input  logic                  req_frame_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CELL_W-1:0]     rsp_merged_cell,
   output logic                  rsp_cell_invalid,
   output logic                  rsp_frame_done,
   output logic [INDEX_W-1:0]    rsp_agree_ratio,
   output logic [1:0]            rsp_index_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   ogcm_cmd_type   cmd;
   ogcm_codes_type codes;

   ogcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .codes       (codes)
   );

   ogcm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_frame_last (req_frame_last),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd)
   );

   ogcm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .codes            (codes),
      .req_ref_cell     (req_ref_cell),
      .req_align_cell   (req_align_cell),
      .rsp_merged_cell  (rsp_merged_cell),
      .rsp_cell_invalid (rsp_cell_invalid),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_agree_ratio  (rsp_agree_ratio),
      .rsp_index_status (rsp_index_status)
   );

endmodule

// ----- bench/ogcm_merge_checker.sv -----
`timescale 1ns / 1ps
module ogcm_merge_checker import ogcm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CELL_W-1:0]     req_ref_cell,
   input  logic [CELL_W-1:0]     req_align_cell,
   input  logic                  req_frame_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [CELL_W-1:0]     rsp_merged_cell,
   input  logic                  rsp_cell_invalid,
   input  logic                  rsp_frame_done,
   input  logic [INDEX_W-1:0]    rsp_agree_ratio,
   input  logic [1:0]            rsp_index_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    failures,
   output int                    pending
);

   typedef struct packed {
      logic [CELL_W-1:0]  merged_cell;
      logic               cell_invalid;
      logic               frame_done;
      logic [INDEX_W-1:0] agree_ratio;
      logic [1:0]         index_status;
   } merged_cell_type;

   ogcm_codes_type    codes;
   logic [COUNT_W-1:0] agree_tally;
   logic [COUNT_W-1:0] disagree_tally;
   logic               foreign_seen;
   merged_cell_type    expected_cells [$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic logic is_known_code(logic [CELL_W-1:0] v);
      return (v == codes.occupied_code) || (v == codes.free_code);
   endfunction

   function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // Merge one pair, update the frame tallies and build the expected result
   function automatic merged_cell_type merge_pair(logic [CELL_W-1:0] r,
                                                  logic [CELL_W-1:0] a,
                                                  logic last);
      merged_cell_type res;
      logic [SUM_W-1:0] known_pairs;
      logic [63:0] scaled;
      res = '0;
      if (r == a)
         res.merged_cell = r;
      else if ((r == codes.occupied_code && a == codes.free_code) ||
               (r == codes.free_code && a == codes.occupied_code))
         res.merged_cell = codes.occupied_code;
      else if (r == codes.unknown_code && is_known_code(a))
         res.merged_cell = a;
      else if (a == codes.unknown_code && is_known_code(r))
         res.merged_cell = r;
      else begin
         res.merged_cell  = codes.unknown_code;
         res.cell_invalid = 1'b1;
      end

      // Flag a bad pair or any cell outside the three codes
      if (res.cell_invalid ||
          !(r == codes.unknown_code || is_known_code(r)) ||
          !(a == codes.unknown_code || is_known_code(a)))
         foreign_seen = 1'b1;

      // Count pairs where both sides are known
      if (!res.cell_invalid && r != codes.unknown_code && a != codes.unknown_code &&
          is_known_code(r) && is_known_code(a)) begin
         if (r == a)
            agree_tally = bump(agree_tally);
         else
            disagree_tally = bump(disagree_tally);
      end

      res.frame_done = last;
      if (last) begin
         known_pairs = SUM_W'(agree_tally) + SUM_W'(disagree_tally);
         if (foreign_seen)
            res.index_status = STATUS_INVALID;
         else if (known_pairs == 0)
            res.index_status = STATUS_NO_KNOWN;
         else begin
            res.index_status = STATUS_OK;
            scaled = 64'(agree_tally) << INDEX_FRAC_BITS;
            res.agree_ratio = INDEX_W'(scaled / 64'(known_pairs));
         end
         agree_tally    = '0;
         disagree_tally = '0;
         foreign_seen   = 1'b0;
      end
      return res;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         failures++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      merged_cell_type want;
      if (reset) begin
         codes.unknown_code  = UNKNOWN_RESET;
         codes.occupied_code = OCCUPIED_RESET;
         codes.free_code     = FREE_RESET;
         agree_tally    = '0;
         disagree_tally = '0;
         foreign_seen   = 1'b0;
         expected_cells.delete();
      end else begin
         // Compare the result transfer against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               failures++;
               $display("%0t: result with none expected, merged_cell %0d", $time,
                        rsp_merged_cell);
            end else begin
               want = expected_cells.pop_front();
               check_field("merged_cell", want.merged_cell, rsp_merged_cell);
               check_field("cell_invalid", want.cell_invalid, rsp_cell_invalid);
               check_field("frame_done", want.frame_done, rsp_frame_done);
               check_field("agree_ratio", want.agree_ratio, rsp_agree_ratio);
               check_field("index_status", want.index_status, rsp_index_status);
            end
         end
         // Predict the pair transfer with the codes in force before this edge
         if (req_valid && req_ready)
            expected_cells.insert(expected_cells.size(),
                                  merge_pair(req_ref_cell, req_align_cell,
                                             req_frame_last));
         // Track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               CSR_UNKNOWN_IDX:  codes.unknown_code  = csr_pwdata[CELL_W-1:0];
               CSR_OCCUPIED_IDX: codes.occupied_code = csr_pwdata[CELL_W-1:0];
               CSR_FREE_IDX:     codes.free_code     = csr_pwdata[CELL_W-1:0];
               default: ;
            endcase
         end
      end
      pending = expected_cells.size();
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb import ogcm_pkg::*; ();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 8;
   localparam int PHASE_PAIRS   = 112;
   localparam int SETTLE_CYCLES = 24;

   typedef struct {
      logic [CELL_W-1:0] ref_cell;
      logic [CELL_W-1:0] align_cell;
      logic              frame_last;
   } cell_pair_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CELL_W-1:0]     req_ref_cell;
   logic [CELL_W-1:0]     req_align_cell;
   logic                  req_frame_last;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [CELL_W-1:0]     rsp_merged_cell;
   logic                  rsp_cell_invalid;
   logic                  rsp_frame_done;
   logic [INDEX_W-1:0]    rsp_agree_ratio;
   logic [1:0]            rsp_index_status;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int             failures;
   int             pending;
   int             cycles = 0;
   int             send_gap_pct = 0;
   int             recv_stall_pct = 0;
   ogcm_codes_type cur_codes;
   ogcm_codes_type phase_codes [PHASES];
   cell_pair_type  pairs [$];

   occupancy_grid_cell_merge_core DUT (.*);

   ogcm_merge_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Random backpressure on the result side
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   function automatic void add_pair(logic [CELL_W-1:0] r, logic [CELL_W-1:0] a,
                                    logic last);
      cell_pair_type p;
      p.ref_cell   = r;
      p.align_cell = a;
      p.frame_last = last;
      pairs.insert(pairs.size(), p);
   endfunction

   function automatic logic [CELL_W-1:0] pick_code();
      case ($urandom_range(2))
         0:       return cur_codes.unknown_code;
         1:       return cur_codes.occupied_code;
         default: return cur_codes.free_code;
      endcase
   endfunction

   function automatic logic [CELL_W-1:0] pick_noisy();
      return ($urandom_range(4) == 0) ? CELL_W'($urandom_range(255)) : pick_code();
   endfunction

   // Build frames of random length: mostly clean, some unknown-heavy, some noisy
   function automatic void queue_frames(int count);
      int made;
      int frame_len;
      int kind;
      int i;
      logic [CELL_W-1:0] r;
      logic [CELL_W-1:0] a;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(9);
         frame_len = ($urandom_range(9) == 0) ? $urandom_range(17, 48) :
                                                $urandom_range(1, 16);
         for (i = 0; i < frame_len && made < count; i++) begin
            if (kind <= 5) begin
               r = pick_code();
               a = pick_code();
            end else if (kind == 6) begin
               if ($urandom_range(1)) begin
                  r = cur_codes.unknown_code;
                  a = pick_code();
               end else begin
                  r = pick_code();
                  a = cur_codes.unknown_code;
               end
            end else begin
               r = pick_noisy();
               a = pick_noisy();
            end
            add_pair(r, a, (i == frame_len - 1) || (made == count - 1));
            made++;
         end
      end
   endfunction

   // Corner pairs under the reset codes (unknown 205, occupied 0, free 254)
   function automatic void queue_corner_pairs();
      add_pair(8'd0,   8'd0,   1'b0);   // occupied agree
      add_pair(8'd254, 8'd254, 1'b0);   // free agree
      add_pair(8'd0,   8'd254, 1'b0);   // occupied against free
      add_pair(8'd254, 8'd0,   1'b0);
      add_pair(8'd205, 8'd0,   1'b0);   // unknown against known
      add_pair(8'd254, 8'd205, 1'b0);
      add_pair(8'd205, 8'd205, 1'b0);   // both unknown
      add_pair(8'd0,   8'd0,   1'b1);   // index 3/5
      add_pair(8'd205, 8'd205, 1'b1);   // no known pairs
      add_pair(8'd205, 8'd254, 1'b1);   // unknown mix, still no known pairs
      add_pair(8'd77,  8'd77,  1'b0);   // foreign code merges but taints frame
      add_pair(8'd0,   8'd0,   1'b1);
      add_pair(8'd205, 8'd100, 1'b0);   // no merge rule
      add_pair(8'd255, 8'd1,   1'b0);
      add_pair(8'd0,   8'd0,   1'b1);
      add_pair(8'd0,   8'd0,   1'b0);   // full agreement
      add_pair(8'd254, 8'd254, 1'b1);
      add_pair(8'd0,   8'd254, 1'b1);   // full disagreement
      add_pair(8'd255, 8'd255, 1'b0);
      add_pair(8'd0,   8'd255, 1'b1);
      add_pair(8'd254, 8'd0,   1'b1);   // lone disagreement right after a bad frame
   endfunction

   // Register write: setup then access; leaves psel high for a following write
   task automatic write_register(logic [1:0] idx, logic [CELL_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= {(CSR_DATA_W-CELL_W)'($urandom()), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
   endtask

   // Send queued pairs with random gaps; called at a falling edge
   task automatic stream_pairs();
      cell_pair_type p;
      while (pairs.size() > 0) begin
         p = pairs.pop_front();
         while ($urandom_range(99) < send_gap_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid      <= 1'b1;
         req_ref_cell   <= p.ref_cell;
         req_align_cell <= p.align_cell;
         req_frame_last <= p.frame_last;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int phase;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_ref_cell   <= '0;
      req_align_cell <= '0;
      req_frame_last <= 1'b0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;

      // Code sets per phase: unknown, occupied, free
      phase_codes[0] = {UNKNOWN_RESET, OCCUPIED_RESET, FREE_RESET};
      phase_codes[1] = {8'd0,   8'd255, 8'd128};
      phase_codes[2] = {8'd255, 8'd0,   8'd1};
      phase_codes[3] = {8'd7,   8'd200, 8'd200};
      phase_codes[4] = {8'd90,  8'd90,  8'd0};
      phase_codes[5] = {8'd170, 8'd85,  8'd255};
      phase_codes[6] = {8'd33,  8'd33,  8'd33};
      phase_codes[7] = {UNKNOWN_RESET, OCCUPIED_RESET, FREE_RESET};

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (phase = 0; phase < PHASES; phase++) begin
         cur_codes = phase_codes[phase];
         // Reprogram the codes only once the block has drained
         if (phase > 0) begin
            while (pending != 0) @(negedge clock);
            write_register(CSR_UNKNOWN_IDX, cur_codes.unknown_code);
            write_register(CSR_OCCUPIED_IDX, cur_codes.occupied_code);
            write_register(CSR_FREE_IDX, cur_codes.free_code);
            csr_psel    <= 1'b0;
            csr_penable <= 1'b0;
            csr_pwrite  <= 1'b0;
         end
         case (phase % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 59; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 59; end
            default: begin send_gap_pct = 22; recv_stall_pct = 22; end
         endcase
         if (phase == 0)
            queue_corner_pairs();
         queue_frames(PHASE_PAIRS);
         stream_pairs();
      end

      // Drain and let the last frame's divide settle
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/ogcm_pkg.sv
sv/ogcm_csr.sv
sv/ogcm_ctrl.sv
sv/ogcm_datapath.sv
sv/occupancy_grid_cell_merge_core.sv
bench/ogcm_merge_checker.sv
bench/tb.sv
